FILE: rtl/vpw_pkg.sv
package vpw_pkg;

   localparam int COEF_COUNT = 28;
   localparam int MV_COUNT   = 16;
   localparam int PJ_COUNT   = 12;

   localparam logic [2:0] CSR_VP_X      = 3'd0;
   localparam logic [2:0] CSR_VP_Y      = 3'd1;
   localparam logic [2:0] CSR_VP_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_VP_HEIGHT = 3'd3;

   localparam logic FUNC_VERTEX = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   typedef struct packed {
      logic        vld;
      logic        zero;
      logic        neg;
      logic [31:0] dvs;
      logic [31:0] cx;
      logic [31:0] cy;
      logic [31:0] cz;
   } div_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7fff_ffff) begin
         return 32'sh7fff_ffff;
      end else if (v < 64'shffff_ffff_8000_0000) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

FILE: rtl/vertex_project_to_window_core.sv
// Vertex projection core: takes one word per cycle and returns one result word per
// vertex, in order. A load word (tuser set) writes one of 28 matrix coefficients and
// gives no result; a vertex word gives window x, y, depth and a valid flag (tuser).
// The matrix stages feed a bit-per-stage reciprocal divider (one quotient bit per stage),
// which in turn feeds the viewport stages.
// Throughput is one word per cycle; the whole pipeline holds while the result is not taken.
module vertex_project_to_window_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // obj_x, obj_y, obj_z, coef_index, coef_value, zero pad
   input  logic [135:0] req_tdata,
   // func
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // win_x, win_y, win_z
   output logic [95:0]  rsp_tdata,
   // proj_ok
   output logic [0:0]   rsp_tuser,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int NQ = 2 * FRAC_BITS + 1;
   localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

   logic en;
   logic accept;
   logic signed [31:0] obj [3];
   logic [4:0]  cidx;
   logic signed [31:0] cval;

   logic signed [15:0] vp_x_ff, vp_y_ff;
   logic [14:0] vp_w_ff, vp_h_ff;

   logic signed [31:0] mv_ff [vpw_pkg::MV_COUNT];
   logic signed [31:0] pj_ff [vpw_pkg::PJ_COUNT];

   logic signed [63:0] mvp_in [16];
   logic signed [63:0] mvp_ff [16];
   logic v1_ff, l1_ff;
   logic [3:0]  l1_idx_ff;
   logic signed [31:0] l1_val_ff;
   logic ld_in;

   logic signed [31:0] eye_in [4];
   logic signed [31:0] eye_ff [4];
   logic v2_ff, l2_ff;
   logic [3:0]  l2_idx_ff;
   logic signed [31:0] l2_val_ff;

   logic signed [63:0] pjp_in [12];
   logic signed [63:0] pjp_ff [12];
   logic signed [32:0] w3_in, w3_ff;
   logic v3_ff;

   logic signed [31:0] clip_in [3];
   logic signed [31:0] clip_ff [3];
   logic signed [32:0] w4_ff;
   logic v4_ff;
   logic [32:0] wmag;

   vpw_pkg::div_ctl_type div_head;
   vpw_pkg::div_ctl_type dv_ctl_ff [NQ];
   logic [31:0]    dv_rem_ff [NQ];
   logic [NQ-1:0]  dv_q_ff [NQ];

   logic [63:0] q64;
   logic signed [31:0] rcp_in, rcp_ff;
   logic signed [31:0] c5_ff [3];
   logic v5_ff, z5_ff;

   logic signed [63:0] ndp_in [3];
   logic signed [63:0] ndp_ff [3];
   logic v6_ff, z6_ff;

   logic signed [31:0] ndc_in [3];
   logic signed [32:0] ax_in, ay_in, ax_ff, ay_ff;
   logic signed [33:0] zsum;
   logic signed [31:0] wz_in, wz7_ff, wz8_ff;
   logic v7_ff, z7_ff;

   logic signed [63:0] mx_in, my_in, mx_ff, my_ff;
   logic v8_ff, z8_ff;

   logic signed [31:0] wx_in, wy_in;
   logic signed [31:0] wx_ff, wy_ff, wz_ff;
   logic ok_ff, rv_ff;

   assign en         = !rv_ff || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   assign obj[0] = req_tdata[31:0];
   assign obj[1] = req_tdata[63:32];
   assign obj[2] = req_tdata[95:64];
   assign cidx   = req_tdata[100:96];
   assign cval   = req_tdata[132:101];

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_x_ff <= '0;
         vp_y_ff <= '0;
         vp_w_ff <= '0;
         vp_h_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            vpw_pkg::CSR_VP_X:      vp_x_ff <= csr_wdata;
            vpw_pkg::CSR_VP_Y:      vp_y_ff <= csr_wdata;
            vpw_pkg::CSR_VP_WIDTH:  vp_w_ff <= csr_wdata[14:0];
            vpw_pkg::CSR_VP_HEIGHT: vp_h_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // coefficient store: modelview written on entry, projection when the load reaches stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vpw_pkg::MV_COUNT; i++) mv_ff[i] <= '0;
         for (int i = 0; i < vpw_pkg::PJ_COUNT; i++) pj_ff[i] <= '0;
      end else begin
         if (accept && req_tuser[0] == vpw_pkg::FUNC_LOAD && cidx < 5'(vpw_pkg::MV_COUNT)) begin
            mv_ff[cidx[3:0]] <= cval;
         end
         if (en && l2_ff) begin
            pj_ff[l2_idx_ff] <= l2_val_ff;
         end
      end
   end

   // stage 1: modelview products
   always_comb begin
      logic signed [63:0] p;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            p = mv_ff[c*4+r] * obj[c];
            mvp_in[r*4+c] = p >>> FRAC_BITS;
         end
         mvp_in[r*4+3] = 64'(mv_ff[12+r]);
      end
   end

   assign ld_in = req_tuser[0] == vpw_pkg::FUNC_LOAD && cidx >= 5'(vpw_pkg::MV_COUNT)
                  && cidx < 5'(vpw_pkg::COEF_COUNT);

   // stage 2: eye coordinates
   always_comb begin
      logic signed [63:0] s;
      for (int r = 0; r < 4; r++) begin
         s = mvp_ff[r*4] + mvp_ff[r*4+1] + mvp_ff[r*4+2] + mvp_ff[r*4+3];
         eye_in[r] = vpw_pkg::sat32(s);
      end
   end

   // stage 3: projection products and w
   always_comb begin
      logic signed [63:0] p;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            p = pj_ff[c*3+r] * eye_ff[c];
            pjp_in[r*4+c] = p >>> FRAC_BITS;
         end
      end
      w3_in = 33'sd0 - {eye_ff[2][31], eye_ff[2]};
   end

   // stage 4: clip coordinates
   always_comb begin
      logic signed [63:0] s;
      for (int r = 0; r < 3; r++) begin
         s = pjp_ff[r*4] + pjp_ff[r*4+1] + pjp_ff[r*4+2] + pjp_ff[r*4+3];
         clip_in[r] = vpw_pkg::sat32(s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         l1_ff <= 1'b0;
         v2_ff <= 1'b0;
         l2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff     <= accept && req_tuser[0] == vpw_pkg::FUNC_VERTEX;
         l1_ff     <= accept && ld_in;
         l1_idx_ff <= 4'(cidx - 5'(vpw_pkg::MV_COUNT));
         l1_val_ff <= cval;
         mvp_ff    <= mvp_in;
         v2_ff     <= v1_ff;
         l2_ff     <= l1_ff;
         l2_idx_ff <= l1_idx_ff;
         l2_val_ff <= l1_val_ff;
         eye_ff    <= eye_in;
         v3_ff     <= v2_ff;
         pjp_ff    <= pjp_in;
         w3_ff     <= w3_in;
         v4_ff     <= v3_ff;
         clip_ff   <= clip_in;
         w4_ff     <= w3_ff;
      end
   end

   // reciprocal of w: one quotient bit per stage, numerator is one times one
   assign wmag = w4_ff[32] ? (~w4_ff + 33'd1) : w4_ff;

   always_comb begin
      div_head.vld  = v4_ff;
      div_head.zero = w4_ff == 33'sd0;
      div_head.neg  = w4_ff[32];
      div_head.dvs  = wmag[31:0];
      div_head.cx   = clip_ff[0];
      div_head.cy   = clip_ff[1];
      div_head.cz   = clip_ff[2];
   end

   for (genvar k = 0; k < NQ; k++) begin : g_div
      vpw_pkg::div_ctl_type ctl_p;
      logic [31:0]   rem_p;
      logic [NQ-1:0] q_p;
      logic [32:0]   t;
      logic          ge;
      if (k == 0) begin : g_first
         assign ctl_p = div_head;
         assign rem_p = '0;
         assign q_p   = '0;
      end else begin : g_next
         assign ctl_p = dv_ctl_ff[k-1];
         assign rem_p = dv_rem_ff[k-1];
         assign q_p   = dv_q_ff[k-1];
      end
      assign t  = {rem_p, (k == 0) ? 1'b1 : 1'b0};
      assign ge = t >= {1'b0, ctl_p.dvs};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ctl_ff[k].vld <= 1'b0;
         end else if (en) begin
            dv_ctl_ff[k] <= ctl_p;
            dv_rem_ff[k] <= ge ? 32'(t - {1'b0, ctl_p.dvs}) : t[31:0];
            dv_q_ff[k]   <= {q_p[NQ-2:0], ge};
         end
      end
   end

   assign q64 = 64'(dv_q_ff[NQ-1]);

   always_comb begin
      if (dv_ctl_ff[NQ-1].neg) begin
         rcp_in = (q64 > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : 32'sd0 - q64[31:0];
      end else begin
         rcp_in = (q64 > 64'h0000_0000_7fff_ffff) ? 32'sh7fff_ffff : q64[31:0];
      end
   end

   // stage 6: divide by w
   always_comb begin
      logic signed [63:0] p;
      for (int r = 0; r < 3; r++) begin
         p = c5_ff[r] * rcp_ff;
         ndp_in[r] = p >>> FRAC_BITS;
      end
   end

   // stage 7: ndc, x and y shifted to 0 to 2, depth mapped to 0 to 1
   always_comb begin
      for (int r = 0; r < 3; r++) ndc_in[r] = vpw_pkg::sat32(ndp_ff[r]);
      ax_in = {ndc_in[0][31], ndc_in[0]} + ONE;
      ay_in = {ndc_in[1][31], ndc_in[1]} + ONE;
      zsum  = 34'(ndc_in[2]) + 34'(ONE);
      wz_in = 32'(zsum >>> 1);
   end

   // stage 8: viewport scale
   assign mx_in = ax_ff * $signed({1'b0, vp_w_ff});
   assign my_in = ay_ff * $signed({1'b0, vp_h_ff});

   // stage 9: viewport offset
   assign wx_in = vpw_pkg::sat32((mx_ff >>> 1) + (64'(vp_x_ff) <<< FRAC_BITS));
   assign wy_in = vpw_pkg::sat32((my_ff >>> 1) + (64'(vp_y_ff) <<< FRAC_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else if (en) begin
         v5_ff  <= dv_ctl_ff[NQ-1].vld;
         z5_ff  <= dv_ctl_ff[NQ-1].zero;
         rcp_ff <= rcp_in;
         c5_ff[0] <= dv_ctl_ff[NQ-1].cx;
         c5_ff[1] <= dv_ctl_ff[NQ-1].cy;
         c5_ff[2] <= dv_ctl_ff[NQ-1].cz;
         v6_ff  <= v5_ff;
         z6_ff  <= z5_ff;
         ndp_ff <= ndp_in;
         v7_ff  <= v6_ff;
         z7_ff  <= z6_ff;
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         wz7_ff <= wz_in;
         v8_ff  <= v7_ff;
         z8_ff  <= z7_ff;
         mx_ff  <= mx_in;
         my_ff  <= my_in;
         wz8_ff <= wz7_ff;
         rv_ff  <= v8_ff;
         ok_ff  <= !z8_ff;
         wx_ff  <= z8_ff ? 32'sd0 : wx_in;
         wy_ff  <= z8_ff ? 32'sd0 : wy_in;
         wz_ff  <= z8_ff ? 32'sd0 : wz8_ff;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {wz_ff, wy_ff, wx_ff};
   assign rsp_tuser  = ok_ff;

endmodule

FILE: tb/vertex_project_to_window_core_tb.sv
module vertex_project_to_window_core_tb;

   localparam int FB = 16;
   localparam int LAT = 2 * FB + 10;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic signed [31:0] wx;
      logic signed [31:0] wy;
      logic signed [31:0] wz;
      logic               ok;
   } win_type;

   typedef struct {
      logic               fn;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] oz;
      logic [4:0]         idx;
      logic signed [31:0] val;
      logic               chk;
      win_type            want;
   } vec_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_wen;
   logic [2:0]   csr_index;
   logic [15:0]  csr_wdata;

   logic signed [31:0] coefs [vpw_pkg::COEF_COUNT];
   logic signed [63:0] org_x, org_y, size_w, size_h;
   win_type            win_q[$];
   logic               fixed_q[$];
   win_type            fixed_want_q[$];
   int                 mismatches;
   int                 idle_cycles;
   int                 tx_idle_pct;
   int                 rx_idle_pct;
   logic               timed_out;

   vertex_project_to_window_core #(.FRAC_BITS(FB)) i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic logic signed [63:0] fmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p >>> FB;
   endfunction

   function automatic logic signed [31:0] to_win(input logic signed [63:0] n,
                                                 input logic signed [63:0] sz,
                                                 input logic signed [63:0] org);
      logic signed [63:0] t;
      t = ((n + (64'sd1 <<< FB)) * sz) >>> 1;
      return 32'(clamp32(t + org * (64'sd1 <<< FB)));
   endfunction

   function automatic win_type project_vertex(input logic signed [31:0] ox,
                                              input logic signed [31:0] oy,
                                              input logic signed [31:0] oz);
      logic signed [63:0] obj [4];
      logic signed [63:0] eye [4];
      logic signed [63:0] clip [3];
      logic signed [63:0] ndc [3];
      logic signed [63:0] acc, w, rcp;
      win_type r;
      obj[0] = ox;
      obj[1] = oy;
      obj[2] = oz;
      obj[3] = 64'sd1 <<< FB;
      for (int i = 0; i < 4; i++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) acc += fmul(coefs[c * 4 + i], obj[c]);
         eye[i] = clamp32(acc);
      end
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) begin
            acc += fmul(coefs[vpw_pkg::MV_COUNT + c * 3 + i], eye[c]);
         end
         clip[i] = clamp32(acc);
      end
      w = -eye[2];
      r = '0;
      if (w == 0) begin
         return r;
      end
      rcp = clamp32((64'sd1 <<< (2 * FB)) / w);
      for (int i = 0; i < 3; i++) ndc[i] = clamp32(fmul(clip[i], rcp));
      r.wx = to_win(ndc[0], size_w, org_x);
      r.wy = to_win(ndc[1], size_h, org_y);
      r.wz = 32'(clamp32(((64'sd1 <<< FB) + ndc[2]) >>> 1));
      r.ok = 1'b1;
      return r;
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         vpw_pkg::CSR_VP_X:      org_x  = $signed(val);
         vpw_pkg::CSR_VP_Y:      org_y  = $signed(val);
         vpw_pkg::CSR_VP_WIDTH:  size_w = val[14:0];
         vpw_pkg::CSR_VP_HEIGHT: size_h = val[14:0];
         default: ;
      endcase
   endtask

   task automatic send_word(input vec_type v);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= v.fn;
      req_tdata  <= {3'b0, v.val, v.idx, v.oz, v.oy, v.ox};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (v.fn == vpw_pkg::FUNC_LOAD) begin
         if (v.idx < vpw_pkg::COEF_COUNT) coefs[v.idx] = v.val;
      end else begin
         win_q.push_back(project_vertex(v.ox, v.oy, v.oz));
         fixed_q.push_back(v.chk);
         fixed_want_q.push_back(v.want);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (win_q.size() != 0 && !timed_out) @(negedge clock);
      repeat (LAT + 4) @(negedge clock);
   endtask

   function automatic logic [31:0] rnd_fix();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         default: return 32'($signed($urandom_range(8 << FB)) - (4 << FB));
      endcase
   endfunction

   function automatic vec_type rnd_vertex();
      vec_type v;
      v = '{default: '0};
      v.fn  = vpw_pkg::FUNC_VERTEX;
      v.ox  = rnd_fix();
      v.oy  = rnd_fix();
      v.oz  = rnd_fix();
      v.idx = 5'($urandom);
      v.val = $urandom;
      return v;
   endfunction

   function automatic vec_type rnd_load();
      vec_type v;
      v = rnd_vertex();
      v.fn  = vpw_pkg::FUNC_LOAD;
      v.idx = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 28))
                                        : 5'($urandom_range(vpw_pkg::COEF_COUNT - 1));
      v.val = rnd_fix();
      return v;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      win_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser[0]};
         if (win_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = win_q.pop_front();
            if (fixed_q.pop_front() && fixed_want_q[0] != want) begin
               mismatches++;
               if (mismatches <= 10) $display("model disagrees with table: %h vs %h",
                                              want, fixed_want_q[0]);
            end
            void'(fixed_want_q.pop_front());
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: x %h/%h y %h/%h z %h/%h ok %b/%b", want.wx, got.wx,
                           want.wy, got.wy, want.wz, got.wz, want.ok, got.ok);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG && !timed_out) begin
         timed_out = 1'b1;
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      vec_type dir [$];
      vec_type v;
      logic [15:0] vx_set [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0010};
      logic [15:0] sz_set [4] = '{16'h0000, 16'h7fff, 16'h4000, 16'h0280};
      mismatches  = 0;
      idle_cycles = 0;
      timed_out   = 1'b0;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      foreach (coefs[i]) coefs[i] = '0;
      org_x = 0; org_y = 0; size_w = 0; size_h = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // stimulus table: fn, x, y, z, index, value, typed check, expected
      dir = '{
         '{vpw_pkg::FUNC_VERTEX, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 5'h1f,
           32'hffff_ffff, 1'b1, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd0, 32'h0001_0000, 1'b0, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd5, 32'h0001_0000, 1'b0, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd10, 32'h0001_0000, 1'b0, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd14, 32'hfffe_0000, 1'b0, '0},
         '{vpw_pkg::FUNC_VERTEX, 0, 0, 0, 0, 0, 1'b0, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd16, 32'h0001_0000, 1'b0, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd20, 32'h0001_0000, 1'b0, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd24, 32'h0001_0000, 1'b0, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd29, 32'h7fff_0000, 1'b0, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd31, 32'h8000_0000, 1'b0, '0},
         '{vpw_pkg::FUNC_VERTEX, 32'h0001_0000, 32'hffff_0000, 32'hfffe_0000, 0, 0, 1'b0, '0},
         '{vpw_pkg::FUNC_VERTEX, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 1'b0, '0},
         '{vpw_pkg::FUNC_VERTEX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 1'b0, '0},
         '{vpw_pkg::FUNC_VERTEX, 0, 0, 32'h0002_0000, 0, 0, 1'b1, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd27, 32'h7fff_ffff, 1'b0, '0},
         '{vpw_pkg::FUNC_LOAD, 0, 0, 0, 5'd15, 32'h8000_0000, 1'b0, '0},
         '{vpw_pkg::FUNC_VERTEX, 32'h0000_8000, 32'h0000_0001, 32'hffff_ffff, 0, 0, 1'b0, '0}
      };
      write_csr(vpw_pkg::CSR_VP_X, 16'h8000);
      write_csr(vpw_pkg::CSR_VP_Y, 16'h7fff);
      write_csr(vpw_pkg::CSR_VP_WIDTH, 16'h7fff);
      write_csr(vpw_pkg::CSR_VP_HEIGHT, 16'h4000);
      foreach (dir[i]) send_word(dir[i]);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin tx_idle_pct = 13; rx_idle_pct = 59; end
            1: begin tx_idle_pct = 59; rx_idle_pct = 13; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         write_csr(vpw_pkg::CSR_VP_X, vx_set[ph]);
         write_csr(vpw_pkg::CSR_VP_Y, ~vx_set[ph]);
         write_csr(vpw_pkg::CSR_VP_WIDTH, sz_set[ph]);
         write_csr(vpw_pkg::CSR_VP_HEIGHT, sz_set[3 - ph]);
         for (int n = 0; n < 310; n++) begin
            if (n % 40 == 0) begin
               for (int k = 0; k < 6; k++) send_word(rnd_load());
            end
            v = ($urandom_range(9) == 0) ? rnd_load() : rnd_vertex();
            send_word(v);
            if (ph == 1 && n == 180) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
               while (win_q.size() != 0) @(negedge clock);
            end
         end
         drain();
      end

      if (mismatches == 0 && win_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/vpw_pkg.sv
rtl/vertex_project_to_window_core.sv
tb/vertex_project_to_window_core_tb.sv
